[rtl/efw_pkg.sv]
// Shared types and codes for the event flag wait unit.
`timescale 1ns / 1ps
package efw_pkg;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_POST  = 2'd1,
    CMD_WAIT  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_MASK = 2'd1,
    ST_TIMEOUT   = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_START   = 3'b001,
    PH_WAITING = 3'b010,
    PH_TIMEOUT = 3'b100
  } phase_t;

  localparam int OPT_ALL   = 0;
  localparam int OPT_ANY   = 1;
  localparam int OPT_CLEAR = 2;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] flag_mask;
    logic [2:0]  wait_option;
    logic [15:0] wait_ms;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] matched_flags;
  } result_t;

endpackage

[rtl/efw_in_stage.sv]
// Input register stage holding one command item.
`timescale 1ns / 1ps
module efw_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  efw_pkg::item_t in_item,
  output logic          item_valid,
  input  logic          item_ready,
  output efw_pkg::item_t item
);
  import efw_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/efw_core.sv]
// Flag group state, command execution and result register.
`timescale 1ns / 1ps
module efw_core #(
  parameter int FLAG_BITS  = 32,
  parameter int TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  efw_pkg::item_t   item,
  output logic             out_valid,
  input  logic             out_ready,
  output efw_pkg::result_t result
);
  import efw_pkg::*;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  logic [FLAG_BITS-1:0]  flag_r, flag_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] tl_r, tl_nxt;
  logic                  out_valid_r;
  result_t               res_r, res_nxt;

  logic [FLAG_BITS-1:0]  mask;
  logic [FLAG_BITS-1:0]  masked;
  logic [TIMER_BITS-1:0] tl_load;
  logic                  hit;
  logic                  fire;

  assign item_ready = !out_valid_r || out_ready;
  assign fire       = item_valid && item_ready;
  assign out_valid  = out_valid_r;
  assign result     = res_r;

  assign mask    = FLAG_BITS'(item.flag_mask);
  assign masked  = flag_r & mask;
  assign tl_load = ({17'd0, item.wait_ms} > TMAX) ? TIMER_BITS'(TMAX)
                                                  : TIMER_BITS'(item.wait_ms);

  always_comb begin
    if (item.wait_option[OPT_ALL]) begin
      hit = (masked == mask);
    end else if (item.wait_option[OPT_ANY]) begin
      hit = (masked != '0);
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    flag_nxt              = flag_r;
    phase_nxt             = phase_r;
    tl_nxt                = tl_r;
    res_nxt.status        = ST_OK;
    res_nxt.matched_flags = '0;
    unique case (item.command)
      CMD_RESET: begin
        flag_nxt  = '0;
        phase_nxt = PH_START;
      end
      CMD_POST: begin
        if (mask == '0) begin
          res_nxt.status = ST_ZERO_MASK;
        end else begin
          flag_nxt = flag_r | mask;
        end
      end
      CMD_WAIT: begin
        if (mask == '0) begin
          res_nxt.status = ST_ZERO_MASK;
        end else if (hit) begin
          phase_nxt             = PH_START;
          res_nxt.matched_flags = 32'(masked);
          if (item.wait_option[OPT_CLEAR]) begin
            flag_nxt = flag_r & ~mask;
          end
        end else if (item.wait_ms == '0) begin
          res_nxt.status = ST_TIMEOUT;
        end else begin
          unique case (phase_r)
            PH_WAITING: begin
              res_nxt.status = ST_BUSY;
              if (tl_r == '0) begin
                phase_nxt = PH_TIMEOUT;
              end
            end
            PH_TIMEOUT: begin
              res_nxt.status = ST_TIMEOUT;
              phase_nxt      = PH_START;
            end
            default: begin
              res_nxt.status = ST_BUSY;
              tl_nxt         = tl_load;
              phase_nxt      = PH_WAITING;
            end
          endcase
        end
      end
      default: begin
        if (tl_r != '0) begin
          tl_nxt = tl_r - TIMER_BITS'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= '0;
      phase_r     <= PH_START;
      tl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        flag_r  <= flag_nxt;
        phase_r <= phase_nxt;
        tl_r    <= tl_nxt;
      end
      if (item_ready) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/event_flag_wait_unit_top.sv]
// Event flag wait unit: event-flag group with polled waiting and timeout.
//
// Input channel (in_*): one command item per handshake. in_tuser carries the
// command (reset group, post, wait poll, tick); in_tdata carries the mask,
// wait options and timeout. Every item produces exactly one result item on
// the output channel (out_*): out_tuser is the status, out_tdata the matched
// flags of a successful wait (zero otherwise).
// Each item passes the input register, then the flag/phase/timer update and
// the result register, before its result can be taken on the output channel.
// Throughput is one item per cycle; both registers advance together so a new
// item is accepted every cycle while out_tready is high.
// When out_tready is low the result register holds; a full input register
// drops in_tready in the same cycle, an empty one still takes one more item
// and then drops in_tready until the result is taken.
// Synchronous reset (rst_n low) clears the flags, timer and wait phase and
// empties both registers.
`timescale 1ns / 1ps
module event_flag_wait_unit_top #(
  parameter int FLAG_BITS  = 32,
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // flag_mask[31:0], wait_option[34:32], wait_ms[50:35]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // matched_flags[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import efw_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_ready;
  result_t result;

  assign in_item.command     = cmd_t'(in_tuser);
  assign in_item.flag_mask   = in_tdata[31:0];
  assign in_item.wait_option = in_tdata[34:32];
  assign in_item.wait_ms     = in_tdata[50:35];

  efw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  efw_core #(
    .FLAG_BITS  (FLAG_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result     (result)
  );

  assign out_tdata = result.matched_flags;
  assign out_tuser = result.status;

endmodule
